### src/decimal_display_command_sequencer_defines.svh
// Assertion macros used by the decimal display command sequencer checker.
`ifndef DECIMAL_DISPLAY_COMMAND_SEQUENCER_DEFINES_SVH
`define DECIMAL_DISPLAY_COMMAND_SEQUENCER_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define DDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define DDCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/ddcs_pkg.sv
// Shared types, constants and helper functions of the display command sequencer.
`timescale 1ns / 1ps
package ddcs_pkg;

  localparam int unsigned ValueWidth = 18;
  localparam int unsigned NumWidth   = 16;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned StepWidth  = 4;
  localparam int unsigned WidxWidth  = 3;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned MaxDigit   = 9;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutDepth   = 2;

  localparam logic [ValueWidth-1:0] FreqLimit = 18'd60000;
  localparam logic [ValueWidth-1:0] VoltMax   = 18'd9999;

  localparam logic [DataWidth-1:0] CodeBlank    = 8'h0F;
  localparam logic [DataWidth-1:0] DecodeDigits = 8'hFC;
  localparam logic [DataWidth-1:0] DecodeFreq   = 8'hFE;
  localparam logic [DataWidth-1:0] GlyphM       = 8'h6A;
  localparam logic [DataWidth-1:0] GlyphV       = 8'h3E;
  localparam logic [DataWidth-1:0] GlyphH       = 8'h0C;
  localparam logic [DataWidth-1:0] GlyphZ       = 8'h6D;
  localparam logic [DataWidth-1:0] CodeE        = 8'h0B;
  localparam logic [DataWidth-1:0] CodeR        = 8'h05;

  localparam logic [AddrWidth-1:0] AddrDigit8 = 4'd8;
  localparam logic [AddrWidth-1:0] AddrDigit1 = 4'd1;
  localparam logic [AddrWidth-1:0] AddrDecode = 4'd9;
  localparam logic [AddrWidth-1:0] AddrTop    = 4'd9;

  // Steps of the nine-write sequence.
  localparam logic [StepWidth-1:0] StepBlank8 = 4'd0;
  localparam logic [StepWidth-1:0] StepDecode = 4'd1;
  localparam logic [StepWidth-1:0] StepPos7   = 4'd2;
  localparam logic [StepWidth-1:0] StepPos6   = 4'd3;
  localparam logic [StepWidth-1:0] StepPos5   = 4'd4;
  localparam logic [StepWidth-1:0] StepPos4   = 4'd5;
  localparam logic [StepWidth-1:0] StepPos3   = 4'd6;
  localparam logic [StepWidth-1:0] StepPos2   = 4'd7;
  localparam logic [StepWidth-1:0] StepPos1   = 4'd8;

  typedef enum logic [1:0] {
    KIND_VOLT,
    KIND_FREQ,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [NumWidth-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
    logic [DataWidth-1:0] data;
    logic                 last;
  } wr_t;

  // k times the decimal weight 10^widx, wide enough for 9 x 10000.
  function automatic logic [NumWidth:0] weight_multiple(logic [WidxWidth-1:0] widx,
                                                        logic [DigitWidth-1:0] k);
    logic [NumWidth:0] base;
    logic [NumWidth:0] prod;
    case (widx)
      3'd0:    base = 17'd1;
      3'd1:    base = 17'd10;
      3'd2:    base = 17'd100;
      3'd3:    base = 17'd1000;
      3'd4:    base = 17'd10000;
      default: base = 17'd0;
    endcase
    prod = base * {{(NumWidth + 1 - DigitWidth){1'b0}}, k};
    return prod;
  endfunction

endpackage

### src/ddcs_front.sv
// Front end: classifies an incoming request and clamps its value for display.
`timescale 1ns / 1ps
module ddcs_front import ddcs_pkg::*; (
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  frequency_mode_i,
  output cmd_t                  cmd_o
);

  always_comb begin
    cmd_o = '0;
    if (!frequency_mode_i) begin
      cmd_o.kind = KIND_VOLT;
      if (value_i > VoltMax) begin
        cmd_o.value = NumWidth'(VoltMax);
      end else begin
        cmd_o.value = value_i[NumWidth-1:0];
      end
    end else if (value_i <= FreqLimit) begin
      cmd_o.kind  = KIND_FREQ;
      cmd_o.value = value_i[NumWidth-1:0];
    end else begin
      cmd_o.kind  = KIND_ERR;
      cmd_o.value = '0;
    end
  end

endmodule

### src/ddcs_cmd_queue.sv
// Short command queue between the front end and the write sequencer.
`timescale 1ns / 1ps
module ddcs_cmd_queue import ddcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(QueueDepth);

  cmd_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### src/ddcs_back.sv
// Back end: steps through the nine register writes and buffers them for output.
`timescale 1ns / 1ps
module ddcs_back import ddcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [AddrWidth-1:0] reg_address_o,
  output logic [DataWidth-1:0] reg_byte_o,
  output logic                 last_o
);

  localparam int unsigned PtrWidth = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntWidth = $clog2(OutDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(OutDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(OutDepth);

  logic                  busy_q, busy_d;
  kind_e                 kind_q, kind_d;
  logic [NumWidth-1:0]   rem_q, rem_d;
  logic [StepWidth-1:0]  step_q, step_d;

  wr_t                   buf_q [OutDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  logic                  emit, done, load, do_pop, digit_step;
  logic [WidxWidth-1:0]  widx;
  logic [NumWidth:0]     mults [MaxDigit+1];
  logic [DigitWidth-1:0] digit;
  logic [NumWidth:0]     sub;
  logic [NumWidth-1:0]   rem_next;
  wr_t                   wr;

  // Decimal digit of the remainder at the current weight: parallel compares.
  always_comb begin
    widx  = WidxWidth'(StepPos3 - step_q);
    digit = '0;
    sub   = '0;
    for (int k = 0; k <= MaxDigit; k++) begin
      mults[k] = weight_multiple(widx, DigitWidth'(k));
    end
    for (int k = 1; k <= MaxDigit; k++) begin
      if ({1'b0, rem_q} >= mults[k]) begin
        digit = DigitWidth'(k);
        sub   = mults[k];
      end
    end
    rem_next = rem_q - sub[NumWidth-1:0];
  end

  // Address and data of the current write.
  always_comb begin
    wr         = '0;
    digit_step = 1'b0;
    if (step_q == StepBlank8) begin
      wr.address = AddrDigit8;
    end else if (step_q == StepDecode) begin
      wr.address = AddrDecode;
    end else begin
      wr.address = AddrWidth'(AddrTop - step_q);
    end
    wr.last = (step_q == StepPos1);
    case (step_q)
      StepBlank8: wr.data = CodeBlank;
      StepDecode: wr.data = (kind_q == KIND_FREQ) ? DecodeFreq : DecodeDigits;
      StepPos7: begin
        wr.data    = (kind_q == KIND_FREQ) ? {{(DataWidth-DigitWidth){1'b0}}, digit}
                                           : CodeBlank;
        digit_step = 1'b1;
      end
      StepPos6, StepPos5, StepPos4: begin
        wr.data    = (kind_q == KIND_ERR) ? CodeBlank
                                          : {{(DataWidth-DigitWidth){1'b0}}, digit};
        digit_step = 1'b1;
      end
      StepPos3: begin
        wr.data    = (kind_q == KIND_ERR) ? CodeE
                                          : {{(DataWidth-DigitWidth){1'b0}}, digit};
        digit_step = 1'b1;
      end
      StepPos2: begin
        case (kind_q)
          KIND_VOLT: wr.data = GlyphM;
          KIND_FREQ: wr.data = GlyphH;
          default:   wr.data = CodeR;
        endcase
      end
      StepPos1: begin
        case (kind_q)
          KIND_VOLT: wr.data = GlyphV;
          KIND_FREQ: wr.data = GlyphZ;
          default:   wr.data = CodeR;
        endcase
      end
      default: wr.data = CodeBlank;
    endcase
  end

  assign emit      = busy_q && (cnt_q != FullCnt);
  assign done      = emit && (step_q == StepPos1);
  assign load      = cmd_valid_i && (!busy_q || done);
  assign cmd_pop_o = load;
  assign empty_o   = (cnt_q == '0);
  assign do_pop    = pop_i && !empty_o;

  assign reg_address_o = buf_q[rd_ptr_q].address;
  assign reg_byte_o    = buf_q[rd_ptr_q].data;
  assign last_o        = buf_q[rd_ptr_q].last;

  always_comb begin
    busy_d   = busy_q;
    kind_d   = kind_q;
    rem_d    = rem_q;
    step_d   = step_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (emit) begin
      step_d = step_q + 1'b1;
      if (digit_step) begin
        rem_d = rem_next;
      end
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      kind_d = cmd_i.kind;
      rem_d  = cmd_i.value;
      step_d = StepBlank8;
    end
    if (emit) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (emit && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !emit) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= StepBlank8;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      step_q   <= step_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rem_q  <= rem_d;
    if (emit) begin
      buf_q[wr_ptr_q] <= wr;
    end
  end

endmodule

### src/decimal_display_command_sequencer.sv
// Top level of the decimal display command sequencer.
// Requests follow one another at the pace of the write sequencer, which issues
// one register write per cycle into the output buffer while that buffer is not full.
// Reset (asynchronous, active low) empties the command queue and the output buffer.
`timescale 1ns / 1ps
module decimal_display_command_sequencer import ddcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  frequency_mode_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [AddrWidth-1:0]  reg_address_o,
  output logic [DataWidth-1:0]  reg_byte_o,
  output logic                  last_o
);

  // The front end decides how a request is to be shown: millivolts, hertz, or
  // the error pattern for a frequency above range. Voltages above the four-digit
  // range are clamped here, so the back end only ever sees printable values.
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_pop;

  ddcs_front u_front (
    .value_i          (value_i),
    .frequency_mode_i (frequency_mode_i),
    .cmd_o            (front_cmd)
  );

  // A short queue decouples acceptance from sequencing, so that a new request
  // can be taken while the previous one is still being written out.
  ddcs_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The back end walks through the nine writes, extracting one decimal digit
  // per digit write, and picks up the next command in the cycle of the ninth write so
  // that consecutive sequences follow without a gap. Its output buffer keeps
  // the sequencer running while the consumer takes the oldest write.
  ddcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_valid),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (queue_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .reg_address_o (reg_address_o),
    .reg_byte_o    (reg_byte_o),
    .last_o        (last_o)
  );

endmodule

### src/ddcs_checker.sv
// Port-level checker for the display command sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "decimal_display_command_sequencer_defines.svh"
module ddcs_checker import ddcs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [AddrWidth-1:0]  reg_address_o,
  input logic [DataWidth-1:0]  reg_byte_o,
  input logic                  last_o
);

  `DDCS_ASSERT_ALWAYS(a_reset_clears, $rose(rst_ni) |-> (empty && !full), "reset must empty the block")
  `DDCS_ASSERT(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(reg_address_o) && $stable(reg_byte_o) && $stable(last_o)), "stalled write changed")
  `DDCS_ASSERT(a_last_is_digit1, (!empty && last_o) |-> (reg_address_o == AddrDigit1), "final write must go to digit 1")
  `DDCS_ASSERT(a_blank8_first, (!empty && reg_address_o == AddrDigit8) |-> (reg_byte_o == CodeBlank && !last_o), "digit 8 must be blanked")
  `DDCS_ASSERT(a_decode_mask, (!empty && reg_address_o == AddrDecode) |-> (reg_byte_o == DecodeDigits || reg_byte_o == DecodeFreq), "bad decode mask")

endmodule

bind decimal_display_command_sequencer ddcs_checker u_checker (.*);
